>>> rtl/three_axis_position_observer_assert.svh
// Assertion helpers for the position observer.
`ifndef THREE_AXIS_POSITION_OBSERVER_ASSERT_SVH
`define THREE_AXIS_POSITION_OBSERVER_ASSERT_SVH
`ifndef SYNTHESIS
`define TAPO_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("position observer: same-cycle check failed");
`define TAPO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("position observer: next-cycle check failed");
`else
`define TAPO_ASSERT_NOW(label, clk, rstn, ante, cons)
`define TAPO_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/tapo_pkg.sv
package tapo_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int ACC_W  = 64;
    localparam int PROD_W = 52;

    localparam logic signed [ACC_W-1:0] DATA_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] DATA_MIN = -(64'sd1 <<< (DATA_W - 1));
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_POSITION    = 3'd0;
    localparam logic [2:0] REG_GAIN_SPEED       = 3'd1;
    localparam logic [2:0] REG_GAIN_DISTURBANCE = 3'd2;
    localparam logic [2:0] REG_DIST_LIMIT       = 3'd3;
    localparam logic [2:0] REG_HORIZ_SMOOTHING  = 3'd4;
    localparam logic [2:0] REG_VERT_SMOOTHING   = 3'd5;

    typedef enum logic [3:0] {
        LN_IDLE,
        LN_F2A,
        LN_F2B,
        LN_F1A,
        LN_F1B,
        LN_OB1,
        LN_OB2,
        LN_OB3,
        LN_OB4,
        LN_OB5,
        LN_OB6,
        LN_OB7,
        LN_OB8,
        LN_DONE
    } lane_state_t;

    typedef struct packed {
        logic                     idle;
        logic                     done;
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] spd;
        logic signed [DATA_W-1:0] dist_est;
    } lane_out_t;

    // round a Q.32 sum to Q.16 (add half, floor), add base, saturate
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [DATA_W-1:0] base
    );
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] s;
        r = (acc + ROUND_HALF) >>> FRAC_W;
        s = r + ACC_W'(base);
        if (s > DATA_MAX) begin
            s = DATA_MAX;
        end else if (s < DATA_MIN) begin
            s = DATA_MIN;
        end
        return DATA_W'(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_limit(
        input logic signed [DATA_W-1:0] v,
        input logic [DATA_W-2:0]        lim
    );
        logic signed [DATA_W:0] vx;
        logic signed [DATA_W:0] lx;
        logic signed [DATA_W:0] nlx;
        logic signed [DATA_W:0] r;
        vx  = (DATA_W + 1)'(v);
        lx  = $signed({2'b00, lim});
        nlx = -lx;
        if (vx > lx) begin
            r = lx;
        end else if (vx < nlx) begin
            r = nlx;
        end else begin
            r = vx;
        end
        return DATA_W'(r);
    endfunction

endpackage

>>> rtl/tapo_lane.sv
module tapo_lane #(
    parameter bit TWO_STAGE = 1'b1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [15:0]                        time_step,
    input  logic signed [tapo_pkg::DATA_W-1:0] meas,
    input  logic signed [tapo_pkg::DATA_W-1:0] accel_cmd,
    input  logic                               restart,
    input  logic [15:0]                        smoothing,
    input  logic [15:0]                        gain_position,
    input  logic [15:0]                        gain_speed,
    input  logic [15:0]                        gain_disturbance,
    input  logic [tapo_pkg::DATA_W-2:0]        disturbance_limit,
    input  logic                               release_lane,
    output tapo_pkg::lane_out_t                lane_out
);

    localparam int DW = tapo_pkg::DATA_W;
    localparam int AW = tapo_pkg::ACC_W;
    localparam int PW = tapo_pkg::PROD_W;

    tapo_pkg::lane_state_t state_reg, state_next;

    logic [15:0]           dt_reg, dt_next;
    logic signed [DW-1:0]  meas_reg, meas_next;
    logic signed [DW-1:0]  cmd_reg, cmd_next;
    logic                  rst_flag_reg, rst_flag_next;
    logic signed [DW:0]    err_reg, err_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [AW-1:0]  acc_reg, acc_next;
    logic signed [DW-1:0]  s1_reg, s1_next;
    logic signed [DW-1:0]  s2_reg, s2_next;
    logic signed [DW-1:0]  pos_reg, pos_next;
    logic signed [DW-1:0]  spd_reg, spd_next;
    logic signed [DW-1:0]  dist_reg, dist_next;

    logic signed [17:0]    mult_a;
    logic signed [DW+1:0]  mult_b;
    logic [16:0]           coeff_rest;
    logic signed [AW-1:0]  prod_ext;
    logic signed [AW-1:0]  prod_sh;
    logic signed [DW-1:0]  applied;

    assign coeff_rest = 17'h10000 - {1'b0, smoothing};
    assign prod_ext   = AW'(prod_reg);
    assign prod_sh    = prod_ext <<< 8;
    assign applied    = TWO_STAGE ? s2_reg : s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tapo_pkg::LN_IDLE;
            s1_reg    <= '0;
            s2_reg    <= '0;
            pos_reg   <= '0;
            spd_reg   <= '0;
            dist_reg  <= '0;
        end else begin
            state_reg <= state_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            pos_reg   <= pos_next;
            spd_reg   <= spd_next;
            dist_reg  <= dist_next;
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg       <= dt_next;
        meas_reg     <= meas_next;
        cmd_reg      <= cmd_next;
        rst_flag_reg <= rst_flag_next;
        err_reg      <= err_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
    end

    always_comb begin
        state_next    = state_reg;
        dt_next       = dt_reg;
        meas_next     = meas_reg;
        cmd_next      = cmd_reg;
        rst_flag_next = rst_flag_reg;
        err_next      = err_reg;
        acc_next      = acc_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        pos_next      = pos_reg;
        spd_next      = spd_reg;
        dist_next     = dist_reg;
        mult_a        = '0;
        mult_b        = '0;

        // each step from F2A to OB6 issues one product; the next step folds it into acc
        case (state_reg)
            tapo_pkg::LN_IDLE: begin
                if (start) begin
                    dt_next       = time_step;
                    meas_next     = meas;
                    cmd_next      = accel_cmd;
                    rst_flag_next = restart;
                    err_next      = (DW + 1)'(meas) - (DW + 1)'(pos_reg);
                    state_next    = tapo_pkg::LN_F2A;
                end
            end
            tapo_pkg::LN_F2A: begin
                mult_a     = $signed({2'b00, smoothing});
                mult_b     = (DW + 2)'(s2_reg);
                state_next = tapo_pkg::LN_F2B;
            end
            tapo_pkg::LN_F2B: begin
                mult_a     = $signed({1'b0, coeff_rest});
                mult_b     = (DW + 2)'(s1_reg);
                acc_next   = prod_ext;
                state_next = tapo_pkg::LN_F1A;
            end
            tapo_pkg::LN_F1A: begin
                mult_a     = $signed({2'b00, smoothing});
                mult_b     = (DW + 2)'(s1_reg);
                acc_next   = acc_reg + prod_ext;
                state_next = tapo_pkg::LN_F1B;
            end
            tapo_pkg::LN_F1B: begin
                mult_a     = $signed({1'b0, coeff_rest});
                mult_b     = (DW + 2)'(cmd_reg);
                acc_next   = prod_ext;
                s2_next    = tapo_pkg::round_sat(acc_reg, '0);
                state_next = tapo_pkg::LN_OB1;
            end
            tapo_pkg::LN_OB1: begin
                mult_a     = $signed({2'b00, dt_reg});
                mult_b     = (DW + 2)'(spd_reg);
                acc_next   = acc_reg + prod_ext;
                state_next = tapo_pkg::LN_OB2;
            end
            tapo_pkg::LN_OB2: begin
                mult_a     = $signed({2'b00, gain_position});
                mult_b     = (DW + 2)'(err_reg);
                acc_next   = prod_ext;
                s1_next    = tapo_pkg::round_sat(acc_reg, '0);
                state_next = tapo_pkg::LN_OB3;
            end
            tapo_pkg::LN_OB3: begin
                mult_a     = $signed({2'b00, dt_reg});
                mult_b     = (DW + 2)'(dist_reg);
                acc_next   = acc_reg + prod_sh;
                state_next = tapo_pkg::LN_OB4;
            end
            tapo_pkg::LN_OB4: begin
                mult_a     = $signed({2'b00, dt_reg});
                mult_b     = (DW + 2)'(applied);
                acc_next   = prod_ext;
                pos_next   = rst_flag_reg ? meas_reg : tapo_pkg::round_sat(acc_reg, pos_reg);
                state_next = tapo_pkg::LN_OB5;
            end
            tapo_pkg::LN_OB5: begin
                mult_a     = $signed({2'b00, gain_speed});
                mult_b     = (DW + 2)'(err_reg);
                acc_next   = acc_reg + prod_ext;
                state_next = tapo_pkg::LN_OB6;
            end
            tapo_pkg::LN_OB6: begin
                mult_a     = $signed({2'b00, gain_disturbance});
                mult_b     = (DW + 2)'(err_reg);
                acc_next   = acc_reg + prod_sh;
                state_next = tapo_pkg::LN_OB7;
            end
            tapo_pkg::LN_OB7: begin
                acc_next   = prod_sh;
                spd_next   = rst_flag_reg ? '0 : tapo_pkg::round_sat(acc_reg, spd_reg);
                state_next = tapo_pkg::LN_OB8;
            end
            tapo_pkg::LN_OB8: begin
                dist_next  = rst_flag_reg ? '0 :
                             tapo_pkg::clamp_limit(tapo_pkg::round_sat(acc_reg, dist_reg),
                                                   disturbance_limit);
                state_next = tapo_pkg::LN_DONE;
            end
            tapo_pkg::LN_DONE: begin
                if (release_lane) begin
                    state_next = tapo_pkg::LN_IDLE;
                end
            end
            default: begin
                state_next = tapo_pkg::LN_IDLE;
            end
        endcase

        prod_next = mult_a * mult_b;
    end

    always_comb begin
        lane_out.idle     = (state_reg == tapo_pkg::LN_IDLE);
        lane_out.done     = (state_reg == tapo_pkg::LN_DONE);
        lane_out.pos      = pos_reg;
        lane_out.spd      = spd_reg;
        lane_out.dist_est = dist_reg;
    end

endmodule

>>> rtl/tapo_merge.sv
module tapo_merge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tapo_pkg::lane_out_t   lane_out [3],
    output logic                  release_lanes,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pos_x, spd_x, dist_x, pos_y, spd_y, dist_y, pos_z, spd_z, dist_z
    output logic [9*tapo_pkg::DATA_W-1:0] m_tdata
);

    logic                          out_valid_reg, out_valid_next;
    logic [9*tapo_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic                          all_done;

    assign all_done      = lane_out[0].done & lane_out[1].done & lane_out[2].done;
    assign release_lanes = all_done && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (release_lanes) begin
            out_valid_next = 1'b1;
            out_data_next  = {lane_out[2].dist_est, lane_out[2].spd, lane_out[2].pos,
                              lane_out[1].dist_est, lane_out[1].spd, lane_out[1].pos,
                              lane_out[0].dist_est, lane_out[0].spd, lane_out[0].pos};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/three_axis_position_observer.sv
// Three-axis position observer: for each input beat, every axis runs its command
// low-pass filter (two stages on x and y, one on z) and a position/speed/disturbance
// update corrected by the gains times the position error, and one output beat carries
// all nine estimates. Each axis has its own lane with one 18x34 multiplier of its own,
// stepped through ten products, so s_tready returns only once every lane has handed
// its result to the output register, and no new item is accepted before then; that
// register lets the next item start while a result still waits on m_tready. A restart
// beat loads the measured positions and clears speed and disturbance, while the command
// filters keep running. Configuration writes are accepted at any time but belong to
// idle periods; unknown indexes are ignored.
`include "three_axis_position_observer_assert.svh"

module three_axis_position_observer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_step, meas_x, meas_y, meas_z, accel_cmd_x, accel_cmd_y, accel_cmd_z
    input  logic [207:0] s_tdata,
    // restart
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, spd_x, dist_x, pos_y, spd_y, dist_y, pos_z, spd_z, dist_z
    output logic [287:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    localparam int DW = tapo_pkg::DATA_W;

    logic [15:0]   gain_pos_reg;
    logic [15:0]   gain_spd_reg;
    logic [15:0]   gain_dist_reg;
    logic [DW-2:0] dist_limit_reg;
    logic [15:0]   horiz_smooth_reg;
    logic [15:0]   vert_smooth_reg;

    tapo_pkg::lane_out_t lane_out [3];
    logic                merge_release;
    logic                start;
    logic [2:0]          lane_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_pos_reg     <= 16'd264;
            gain_spd_reg     <= 16'd2739;
            gain_dist_reg    <= 16'd2463;
            dist_limit_reg   <= 31'd393216;
            horiz_smooth_reg <= 16'd62259;
            vert_smooth_reg  <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tapo_pkg::REG_GAIN_POSITION:    gain_pos_reg     <= cfg_data[15:0];
                tapo_pkg::REG_GAIN_SPEED:       gain_spd_reg     <= cfg_data[15:0];
                tapo_pkg::REG_GAIN_DISTURBANCE: gain_dist_reg    <= cfg_data[15:0];
                tapo_pkg::REG_DIST_LIMIT:       dist_limit_reg   <= cfg_data;
                tapo_pkg::REG_HORIZ_SMOOTHING:  horiz_smooth_reg <= cfg_data[15:0];
                tapo_pkg::REG_VERT_SMOOTHING:   vert_smooth_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign s_tready  = lane_out[0].idle & lane_out[1].idle & lane_out[2].idle;
    assign start     = s_tvalid && s_tready;
    assign lane_done = {lane_out[2].done, lane_out[1].done, lane_out[0].done};

    tapo_lane #(.TWO_STAGE(1'b1)) u_lane_x (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start             (start),
        .time_step         (s_tdata[15:0]),
        .meas              (s_tdata[47:16]),
        .accel_cmd         (s_tdata[143:112]),
        .restart           (s_tuser),
        .smoothing         (horiz_smooth_reg),
        .gain_position     (gain_pos_reg),
        .gain_speed        (gain_spd_reg),
        .gain_disturbance  (gain_dist_reg),
        .disturbance_limit (dist_limit_reg),
        .release_lane      (merge_release),
        .lane_out          (lane_out[0])
    );

    tapo_lane #(.TWO_STAGE(1'b1)) u_lane_y (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start             (start),
        .time_step         (s_tdata[15:0]),
        .meas              (s_tdata[79:48]),
        .accel_cmd         (s_tdata[175:144]),
        .restart           (s_tuser),
        .smoothing         (horiz_smooth_reg),
        .gain_position     (gain_pos_reg),
        .gain_speed        (gain_spd_reg),
        .gain_disturbance  (gain_dist_reg),
        .disturbance_limit (dist_limit_reg),
        .release_lane      (merge_release),
        .lane_out          (lane_out[1])
    );

    tapo_lane #(.TWO_STAGE(1'b0)) u_lane_z (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .start             (start),
        .time_step         (s_tdata[15:0]),
        .meas              (s_tdata[111:80]),
        .accel_cmd         (s_tdata[207:176]),
        .restart           (s_tuser),
        .smoothing         (vert_smooth_reg),
        .gain_position     (gain_pos_reg),
        .gain_speed        (gain_spd_reg),
        .gain_disturbance  (gain_dist_reg),
        .disturbance_limit (dist_limit_reg),
        .release_lane      (merge_release),
        .lane_out          (lane_out[2])
    );

    tapo_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .lane_out      (lane_out),
        .release_lanes (merge_release),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    // an accepted beat puts every lane to work
    `TAPO_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, start, !s_tready)
    // lanes run the same schedule and finish together
    `TAPO_ASSERT_NOW(a_lanes_lockstep, aclk, aresetn, 1'b1, (~|lane_done || &lane_done))
    // a merged result shows up on the output
    `TAPO_ASSERT_NEXT(a_merge_to_output, aclk, aresetn, merge_release, m_tvalid)

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int          QUIET_CYCLES = 24;
    localparam int unsigned RUN_LIMIT    = 600000;
    localparam logic [2:0]  REG_SPARE_A  = 3'd6;
    localparam logic [2:0]  REG_SPARE_B  = 3'd7;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // time_step, meas_x, meas_y, meas_z, accel_cmd_x, accel_cmd_y, accel_cmd_z
    logic [207:0] s_tdata;
    // restart
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // pos_x, spd_x, dist_x, pos_y, spd_y, dist_y, pos_z, spd_z, dist_z
    logic [287:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_data;

    three_axis_position_observer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    // observer copy: gains, limit, filter coefficients and per-axis estimates
    longint kp = 264;
    longint ks = 2739;
    longint kd = 2463;
    longint dist_lim = 393216;
    longint alpha_h = 62259;
    longint alpha_v = 0;
    longint obs_pos [3];
    longint obs_spd [3];
    longint obs_dist [3];
    longint filt_one [3];
    longint filt_two [2];

    logic [287:0] expected_est [$];
    int           bad_fields = 0;
    int unsigned  cycle_count = 0;
    bit           src_lazy = 1'b0;
    bit           sink_lazy = 1'b0;
    int           sink_hold = 0;
    string        est_name [9] = '{"pos_x", "spd_x", "dist_x", "pos_y", "spd_y", "dist_y",
                                   "pos_z", "spd_z", "dist_z"};

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q.32 to Q.16: add half, floor
    function automatic longint rnd16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint lowpass(longint c, longint prev, longint cur);
        return clip32(rnd16(c * prev + (64'sd65536 - c) * cur));
    endfunction

    function automatic logic [287:0] step_observer(logic [207:0] beat, logic restart);
        longint       dt;
        longint       meas [3];
        longint       cmd [3];
        longint       applied [3];
        longint       e;
        longint       np;
        longint       ns;
        longint       nd;
        logic [287:0] est;
        int           k;
        dt = longint'(beat[15:0]);
        for (k = 0; k < 3; k++) begin
            meas[k] = longint'($signed(beat[16 + 32 * k +: 32]));
            cmd[k]  = longint'($signed(beat[112 + 32 * k +: 32]));
        end
        // second stage takes the first-stage value from before this beat
        for (k = 0; k < 2; k++) filt_two[k] = lowpass(alpha_h, filt_two[k], filt_one[k]);
        for (k = 0; k < 2; k++) filt_one[k] = lowpass(alpha_h, filt_one[k], cmd[k]);
        filt_one[2] = lowpass(alpha_v, filt_one[2], cmd[2]);
        applied[0] = filt_two[0];
        applied[1] = filt_two[1];
        applied[2] = filt_one[2];
        for (k = 0; k < 3; k++) begin
            e  = meas[k] - obs_pos[k];
            np = clip32(obs_pos[k] + rnd16(dt * obs_spd[k] + kp * e * 256));
            ns = clip32(obs_spd[k] + rnd16(dt * obs_dist[k] + dt * applied[k] + ks * e * 256));
            nd = clip32(obs_dist[k] + rnd16(kd * e * 256));
            if (nd > dist_lim) nd = dist_lim;
            if (nd < -dist_lim) nd = -dist_lim;
            if (restart) begin
                np = meas[k];
                ns = 0;
                nd = 0;
            end
            obs_pos[k]  = np;
            obs_spd[k]  = ns;
            obs_dist[k] = nd;
            est[96 * k +: 32]      = np[31:0];
            est[96 * k + 32 +: 32] = ns[31:0];
            est[96 * k + 64 +: 32] = nd[31:0];
        end
        return est;
    endfunction

    function automatic int pick_gap(bit lazy);
        int r;
        if (!lazy) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [30:0] corner_or_any();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            tapo_pkg::REG_GAIN_POSITION:    kp = longint'(val[15:0]);
            tapo_pkg::REG_GAIN_SPEED:       ks = longint'(val[15:0]);
            tapo_pkg::REG_GAIN_DISTURBANCE: kd = longint'(val[15:0]);
            tapo_pkg::REG_DIST_LIMIT:       dist_lim = longint'(val);
            tapo_pkg::REG_HORIZ_SMOOTHING:  alpha_h = longint'(val[15:0]);
            tapo_pkg::REG_VERT_SMOOTHING:   alpha_v = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic program_all(logic [30:0] gp, logic [30:0] gs, logic [30:0] gd,
                               logic [30:0] lim, logic [30:0] ah, logic [30:0] av);
        write_reg(tapo_pkg::REG_GAIN_POSITION, gp);
        write_reg(tapo_pkg::REG_GAIN_SPEED, gs);
        write_reg(tapo_pkg::REG_GAIN_DISTURBANCE, gd);
        write_reg(tapo_pkg::REG_DIST_LIMIT, lim);
        write_reg(tapo_pkg::REG_HORIZ_SMOOTHING, ah);
        write_reg(tapo_pkg::REG_VERT_SMOOTHING, av);
        cfg_valid <= 1'b0;
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_item(logic [15:0] dt, logic [31:0] mx, logic [31:0] my,
                             logic [31:0] mz, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic rst);
        logic [207:0] beat;
        beat = {cz, cy, cx, mz, my, mx, dt};
        pause_sender(pick_gap(src_lazy));
        s_tdata  <= beat;
        s_tuser  <= rst;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_est.push_back(step_observer(beat, rst));
    endtask

    // hold the source until every estimate is back, then let the lanes go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_est.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic test_directed_defaults();
        send_item(16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(16'h0400, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                  32'h0, 32'h0, 32'h0, 1'b1);
        send_item(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                  32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_item(16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_item(16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_item(16'h0000, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        // filters keep running across a restart
        send_item(16'h1000, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h12345678, 1'b1);
        send_item(16'h0147, 32'h00018000, 32'hFFFE8000, 32'h00004000,
                  32'h00020000, 32'hFFFF0000, 32'h00008000, 1'b0);
        settle();
    endtask

    task automatic test_extreme_settings();
        program_all(31'hFFFF, 31'hFFFF, 31'hFFFF, 31'h7FFFFFFF, 31'hFFFF, 31'hFFFF);
        send_item(16'h0100, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        send_item(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_item(16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        settle();
        // zero limit pins the disturbance estimate at zero
        program_all(31'h0, 31'h0, 31'h0, 31'h0, 31'h0, 31'h0);
        send_item(16'hFFFF, 32'h40000000, 32'hC0000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_item(16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h00000001,
                  32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        settle();
        program_all(31'h0108, 31'h0AB3, 31'h099F, 31'h0, 31'hF333, 31'h0);
        send_item(16'h2000, 32'h00050000, 32'hFFFB0000, 32'h00030000,
                  32'h00010000, 32'hFFFF0000, 32'h00002000, 1'b0);
        settle();
    endtask

    task automatic test_ignored_index();
        write_reg(REG_SPARE_A, 31'h0000_0000);
        write_reg(REG_SPARE_B, 31'h7FFF_FFFF);
        // only the low 16 bits of a value written to a gain register take effect
        write_reg(tapo_pkg::REG_GAIN_POSITION, 31'h5A5A_0108);
        write_reg(tapo_pkg::REG_DIST_LIMIT, 31'd393216);
        cfg_valid <= 1'b0;
        send_item(16'h0200, 32'h00030000, 32'h00040000, 32'h00050000,
                  32'h0, 32'h0, 32'h0, 1'b1);
        send_item(16'h0200, 32'h00031000, 32'h0003F000, 32'h00050800,
                  32'h00010000, 32'h00020000, 32'hFFFF0000, 1'b0);
        send_item(16'h0200, 32'h00032000, 32'h0003E000, 32'h00051000,
                  32'h00010000, 32'h00020000, 32'hFFFF0000, 1'b0);
        settle();
    endtask

    task automatic test_random_tracking();
        int     phase;
        int     n;
        int     i;
        int     a;
        int     run_len;
        bit     held;
        int     tp [3];
        int     tv [3];
        int     mv [3];
        int     cv [3];
        logic [15:0] dt;
        held = 1'b0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: program_all(31'd264, 31'd2739, 31'd2463, 31'd393216, 31'd62259, 31'd0);
                1: program_all(31'($urandom), 31'($urandom), 31'($urandom),
                               31'($urandom), 31'($urandom), 31'($urandom));
                2: program_all(31'($urandom_range(0, 4095)), 31'($urandom_range(0, 4095)),
                               31'($urandom_range(0, 4095)),
                               31'($urandom_range(0, 32'h0010_0000)),
                               31'($urandom), 31'($urandom));
                default: program_all(corner_or_any(), corner_or_any(), corner_or_any(),
                                     corner_or_any(), corner_or_any(), corner_or_any());
            endcase
            n = 0;
            while (n < 150) begin
                src_lazy  = (phase != 0) && ($urandom_range(0, 3) != 0);
                sink_lazy = (phase != 0) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) < 2) begin
                    send_item(16'($urandom), $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
                    n++;
                end else begin
                    for (a = 0; a < 3; a++) begin
                        tp[a] = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
                        tv[a] = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
                    end
                    send_item(16'($urandom_range(100, 3000)), tp[0], tp[1], tp[2],
                              32'h0, 32'h0, 32'h0, 1'b1);
                    n++;
                    run_len = $urandom_range(4, 30);
                    for (i = 0; i < run_len; i++) begin
                        dt = 16'($urandom_range(100, 3000));
                        for (a = 0; a < 3; a++) begin
                            tv[a] = tv[a] + int'($urandom_range(0, 8191)) - 4096;
                            tp[a] = tp[a] + int'((longint'(tv[a]) * longint'(dt)) >>> 16);
                            mv[a] = tp[a] + int'($urandom_range(0, 511)) - 256;
                            cv[a] = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
                        end
                        send_item(dt, mv[0], mv[1], mv[2], cv[0], cv[1], cv[2], 1'b0);
                        n++;
                    end
                end
                if (phase == 1 && !held && n >= 75) begin
                    settle();
                    held = 1'b1;
                end
            end
            settle();
        end
        src_lazy  = 1'b0;
        sink_lazy = 1'b0;
    endtask

    always @(posedge aclk) begin : sink_pace
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            sink_hold = pick_gap(sink_lazy);
            m_tready <= (sink_hold == 0);
        end
    end

    always @(posedge aclk) begin : check_estimates
        logic [287:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_est.size() == 0) begin
                $display("%0t: estimate beat with none expected, actual %h", $time, m_tdata);
                bad_fields++;
            end else begin
                want = expected_est.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (m_tdata[32 * k +: 32] !== want[32 * k +: 32]) begin
                        $display("%0t: %s expected %0d actual %0d", $time, est_name[k],
                                 $signed(want[32 * k +: 32]), $signed(m_tdata[32 * k +: 32]));
                        bad_fields++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_defaults();
        test_extreme_settings();
        test_ignored_index();
        test_random_tracking();
        settle();
        if (bad_fields == 0 && expected_est.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> three_axis_position_observer.f
+incdir+rtl
rtl/tapo_pkg.sv
rtl/tapo_lane.sv
rtl/tapo_merge.sv
rtl/three_axis_position_observer.sv
bench/tb.sv
